// ===== hw/rtl/huber_loss_reduce_top_macros.svh =====
// Assertion macros for the Huber loss reduction block.
`ifndef HUBER_LOSS_REDUCE_TOP_MACROS_SVH
`define HUBER_LOSS_REDUCE_TOP_MACROS_SVH

// Implication checked on the next clock, off while in reset.
`define HLR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("hlr: next-cycle check failed");

// Implication checked on the next clock, reset included.
`define HLR_ASSERT_RST_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("hlr: reset check failed");

// Same-cycle implication, reset included.
`define HLR_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |-> (expr)) \
    else $error("hlr: same-cycle check failed");

`endif

// ===== hw/rtl/hlr_pkg.sv =====
// Shared types and constants for the Huber loss reduction block.
package hlr_pkg;

  localparam int DATA_W           = 16;
  localparam int LOSS_W           = 48;
  localparam int ELOSS_W          = 34;
  localparam int MODE_W           = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_ELEMENTS_DEF = 65536;
  localparam int QDEPTH           = 4;
  localparam int QA_W             = 2;

  localparam logic [DATA_W-1:0] DELTA_RST = 16'd256;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

  typedef struct packed {
    logic [ELOSS_W-1:0] loss;
    logic               last;
  } eloss_t;

endpackage

// ===== hw/rtl/hlr_front.sv =====
// Front end: difference, threshold compare and element loss pipeline.
module hlr_front import hlr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_pred,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic                     in_last,
  input  logic [DATA_W-1:0]        delta,
  output logic                     q_push,
  output eloss_t                   q_data,
  input  logic                     q_full
);

  logic                      a_v_r, b_v_r;
  logic                      a_en, b_en;
  logic signed [DATA_W:0]    diff;
  logic [DATA_W-1:0]         ad_in;
  logic [DATA_W-1:0]         ad_r;
  logic                      a_le_r, a_last_r;
  logic [DATA_W-1:0]         mul_a;
  logic [2*DATA_W-1:0]       prod_r;
  logic [2*DATA_W-1:0]       dsq_r;
  logic                      b_le_r, b_last_r;
  logic [ELOSS_W-1:0]        lin_term;

  assign diff     = {in_pred[DATA_W-1], in_pred} - {in_target[DATA_W-1], in_target};
  assign ad_in    = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];

  assign b_en     = !b_v_r || !q_full;
  assign a_en     = !a_v_r || b_en;
  assign in_ready = a_en;
  assign mul_a    = a_le_r ? ad_r : delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_en) a_v_r <= in_valid;
      if (b_en) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dsq_r <= delta * delta;
    if (a_en) begin
      ad_r     <= ad_in;
      a_le_r   <= (ad_in <= delta);
      a_last_r <= in_last;
    end
    if (b_en) begin
      prod_r   <= mul_a * ad_r;
      b_le_r   <= a_le_r;
      b_last_r <= a_last_r;
    end
  end

  // 2*delta*ad - delta^2, positive above the threshold
  assign lin_term = {1'b0, prod_r, 1'b0} - {2'b00, dsq_r};

  assign q_push      = b_v_r && !q_full;
  assign q_data.loss = b_le_r ? {3'b000, prod_r[2*DATA_W-1:1]} : (lin_term >> 1);
  assign q_data.last = b_last_r;

endmodule

// ===== hw/rtl/hlr_fifo.sv =====
// Small queue between the loss front end and the reduction back end.
module hlr_fifo import hlr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  eloss_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output eloss_t pop_data
);

  eloss_t            mem_r [QDEPTH];
  logic [QA_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QA_W:0]     cnt_r;

  assign full     = (cnt_r == (QA_W+1)'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/hlr_back.sv =====
// Back end: accumulation, mean divider and output register.
module hlr_back import hlr_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  input  logic              q_valid,
  input  eloss_t            q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LOSS_W-1:0] out_data,
  output logic              out_last
);

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int STEP_W = $clog2(LOSS_W + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_ELEMENTS);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(LOSS_W);

  typedef enum logic {ST_RUN, ST_DIV} state_t;

  state_t              state_r;
  logic [LOSS_W-1:0]   sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [LOSS_W-1:0]   quo_r;
  logic [CNT_W-1:0]    rem_r, dvs_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r, out_last_r;
  logic [LOSS_W-1:0]   out_data_r;

  logic                is_acc, produces, out_free, out_load;
  logic [LOSS_W:0]     sum_ext;
  logic [LOSS_W-1:0]   sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [CNT_W:0]      trial;
  logic                ge;
  logic [CNT_W:0]      trial_sub;

  assign is_acc   = (mode == MODE_MEAN) || (mode == MODE_SUM);
  assign produces = !is_acc || q_data.last;
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == ST_RUN) && q_valid && (!produces || out_free);

  // output register loads on a per-element or sum beat, or a finished divide
  assign out_load = (state_r == ST_RUN) ?
                    (q_pop && produces && !(is_acc && (mode == MODE_MEAN))) :
                    ((step_r == '0) && out_free);

  assign sum_ext = {1'b0, sum_r} + (LOSS_W+1)'(q_data.loss);
  assign sum_new = sum_ext[LOSS_W] ? {LOSS_W{1'b1}} : sum_ext[LOSS_W-1:0];
  assign cnt_new = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // restoring divide, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[LOSS_W-1]};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign trial_sub = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sum_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_RUN: begin
          if (q_pop) begin
            if (!is_acc) begin
              out_data_r  <= LOSS_W'(q_data.loss);
              out_last_r  <= q_data.last;
            end else if (!q_data.last) begin
              sum_r <= sum_new;
              cnt_r <= cnt_new;
            end else begin
              sum_r <= '0;
              cnt_r <= '0;
              if (mode == MODE_SUM) begin
                out_data_r  <= sum_new;
                out_last_r  <= 1'b1;
              end else begin
                quo_r   <= sum_new;
                rem_r   <= '0;
                dvs_r   <= cnt_new;
                step_r  <= DIV_STEPS;
                state_r <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (step_r != '0) begin
            quo_r  <= {quo_r[LOSS_W-2:0], ge};
            rem_r  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            step_r <= step_r - 1'b1;
          end else if (out_free) begin
            out_data_r  <= quo_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/huber_loss_reduce_top.sv =====
// Huber loss with none, mean or sum reduction over a stream of Q8.8 pairs.
//
// Input channel: one beat carries a prediction and a target (signed Q8.8)
// in in_tdata and the end-of-set mark in in_tlast.
// Output channel: out_tdata carries the Q.16 loss, out_tlast closes a set.
// Config channel: index 0 is delta (Q8.8), index 1 the reduction mode;
// cfg_ready is always high, write only while the block is idle.
// Front end takes one beat per cycle unless the queue is full, and pushes
// the loss from its product register into a 4-entry queue. The back end
// drains one entry per cycle while the output register is free, so mode
// none and sum run at one beat per cycle as well. In mean mode the closing
// beat starts a bit-serial divider that then loads the output register;
// no queue entries are taken meanwhile, the front keeps filling the queue.
// Reset restores delta 1.0, mean mode, and clears sum, count and queue.
// A stalled receiver holds the output register; the queue then fills and
// in_tready drops.
module huber_loss_reduce_top import hlr_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*DATA_W-1:0]  in_tdata,   // pred_value, target_value
  input  logic                 in_tlast,   // last_element
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [LOSS_W-1:0]    out_tdata,  // loss_value
  output logic                 out_tlast,  // end_of_set
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic [DATA_W-1:0] delta_r;
  logic [MODE_W-1:0] mode_r;
  logic              q_push, q_full, q_pop, q_valid;
  eloss_t            q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RST;
      mode_r  <= MODE_MEAN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELTA: delta_r <= cfg_data;
        CFG_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  hlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pred   (in_tdata[DATA_W-1:0]),
    .in_target (in_tdata[2*DATA_W-1:DATA_W]),
    .in_last   (in_tlast),
    .delta     (delta_r),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  hlr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  hlr_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== hw/rtl/hlr_checker.sv =====
// Port-level checks for the Huber loss reduction block, bound to the top.
`include "huber_loss_reduce_top_macros.svh"

module hlr_checker import hlr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [LOSS_W-1:0] out_tdata,
  input logic              out_tlast
);

  `HLR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `HLR_ASSERT_RST_NEXT(a_rst_no_out, !rst_n, !out_tvalid)
  `HLR_ASSERT_RST_NEXT(a_rst_ready, !rst_n, in_tready)
  `HLR_ASSERT_NOW(a_out_after_rst, rst_n && $rose(out_tvalid), $past(rst_n))

endmodule

bind huber_loss_reduce_top hlr_checker u_hlr_checker (.*);

// ===== verif/tb.sv =====
// Testbench for huber_loss_reduce_top: scoreboard check of per-beat, sum and mean Huber loss.
`timescale 1ns / 100ps

module tb;
  import hlr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ELEM_CAP     = MAX_ELEMENTS_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int SAT_RUN      = 60;
  localparam int SEGMENTS     = 10;
  localparam int SEG_BEATS    = 35;

  class loss_scoreboard;
    typedef struct packed {
      logic [LOSS_W-1:0] loss;
      logic              last;
    } loss_beat_t;

    localparam logic [LOSS_W-1:0] SUM_LIMIT = {LOSS_W{1'b1}};

    loss_beat_t        loss_q[$];
    logic [DATA_W-1:0] delta;
    logic [MODE_W-1:0] mode;
    logic [LOSS_W-1:0] run_sum;
    int unsigned       run_count;
    int unsigned       cap;
    int                errors;
    int                checked;
    int                beats;
    int                writes;

    function new(int unsigned max_elems);
      cap       = max_elems;
      delta     = DELTA_RST;
      mode      = MODE_MEAN;
      run_sum   = '0;
      run_count = 0;
      errors    = 0;
      checked   = 0;
      beats     = 0;
      writes    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      writes++;
      if (idx == CFG_DELTA) delta = val;
      else if (idx == CFG_MODE) mode = val[MODE_W-1:0];
    endfunction

    function logic [LOSS_W-1:0] huber_term(logic [DATA_W-1:0] p, logic [DATA_W-1:0] t);
      logic [DATA_W:0]   diff;
      logic [DATA_W-1:0] ad;
      logic [63:0]       a;
      logic [63:0]       d;
      diff = {p[DATA_W-1], p} - {t[DATA_W-1], t};
      ad   = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
      a    = 64'(ad);
      d    = 64'(delta);
      if (a <= d) return LOSS_W'((a * a) >> 1);
      return LOSS_W'(((64'd2 * d * a) - (d * d)) >> 1);
    endfunction

    function void note_input(logic [DATA_W-1:0] p, logic [DATA_W-1:0] t, logic last);
      logic [LOSS_W-1:0] loss;
      loss_beat_t        res;
      loss = huber_term(p, t);
      beats++;
      if (mode != MODE_MEAN && mode != MODE_SUM) begin
        res.loss = loss;
        res.last = last;
        loss_q.push_back(res);
        return;
      end
      if (loss > SUM_LIMIT - run_sum) run_sum = SUM_LIMIT;
      else run_sum = run_sum + loss;
      if (run_count < cap) run_count++;
      if (!last) return;
      res.loss = (mode == MODE_MEAN) ? run_sum / LOSS_W'(run_count) : run_sum;
      res.last = 1'b1;
      loss_q.push_back(res);
      run_sum   = '0;
      run_count = 0;
    endfunction

    task report(string msg);
      if (errors < 100) $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [LOSS_W-1:0] loss, logic last);
      loss_beat_t want;
      checked++;
      if (loss_q.size() == 0) begin
        report($sformatf("unexpected beat loss=%0h last=%0b", loss, last));
        return;
      end
      want = loss_q.pop_front();
      if (loss !== want.loss)
        report($sformatf("beat %0d loss %0h, want %0h", checked, loss, want.loss));
      if (last !== want.last)
        report($sformatf("beat %0d tlast %0b, want %0b", checked, last, want.last));
    endtask

    function int pending();
      return loss_q.size();
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [2*DATA_W-1:0]  in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [LOSS_W-1:0]    out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DATA_W-1:0]    cfg_data   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  loss_scoreboard sb;

  huber_loss_reduce_top #(.MAX_ELEMENTS(ELEM_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // pred_value, target_value
    .in_tlast   (in_tlast),   // last_element
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // loss_value
    .out_tlast  (out_tlast),  // end_of_set
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic send_beat(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, p};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(p, t, last);
  endtask

  // stop sending, let every expected beat arrive, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] delta, input logic [MODE_W-1:0] mode);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DELTA;
    cfg_data  <= delta;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_DELTA, delta);
    cfg_index <= CFG_MODE;
    cfg_data  <= DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_MODE, DATA_W'(mode));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_segment(input bit pause_mid);
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] delta;
    logic [MODE_W-1:0] mode;
    logic              last;
    case ($urandom_range(5))
      0:       delta = '0;
      1:       delta = '1;
      2:       delta = DELTA_RST;
      default: delta = DATA_W'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1, 2: mode = MODE_NONE;
      3, 4, 5: mode = MODE_MEAN;
      6, 7, 8: mode = MODE_SUM;
      default: mode = MODE_UNUSED;
    endcase
    set_regs(delta, mode);
    for (int n = 0; n < SEG_BEATS; n++) begin
      if (pause_mid && n == SEG_BEATS / 2) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      p = DATA_W'($urandom);
      case ($urandom_range(3))
        0: t = DATA_W'($urandom);
        1: begin
          off = delta + DATA_W'($urandom_range(2)) - 1'b1;
          t   = $urandom_range(1) ? p - off : p + off;
        end
        2: t = p + DATA_W'($urandom_range(15)) - DATA_W'(8);
        default: t = p;
      endcase
      last = ($urandom_range(5) == 0) || (n == SEG_BEATS - 1);
      send_beat(p, t, last);
    end
  endtask

  initial begin
    int idle_of[4];
    int stall_of[4];
    idle_of  = '{0, 50, 0, 29};
    stall_of = '{0, 0, 50, 29};
    sb = new(ELEM_CAP);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: mean mode, delta 1.0
    send_beat(16'h0100, 16'h0000, 1'b0);
    send_beat(16'h7fff, 16'h8000, 1'b1);

    set_regs(DELTA_RST, MODE_NONE);
    send_beat(16'h1234, 16'h1234, 1'b0);
    send_beat(16'h0100, 16'h0000, 1'b0);
    send_beat(16'h0000, 16'h0101, 1'b0);
    send_beat(16'h0001, 16'h0000, 1'b0);
    send_beat(16'h0003, 16'h0000, 1'b1);
    send_beat(16'h7fff, 16'h8000, 1'b0);
    send_beat(16'h8000, 16'h7fff, 1'b1);

    set_regs(16'h0000, MODE_NONE);
    send_beat(16'h7fff, 16'h8000, 1'b0);
    send_beat(16'h0001, 16'h0000, 1'b1);

    set_regs(16'hffff, MODE_UNUSED);
    send_beat(16'h7fff, 16'h8000, 1'b1);
    send_beat(16'h8000, 16'h7fff, 1'b0);

    // partial set carried across mode changes
    set_regs(16'h0080, MODE_MEAN);
    send_beat(16'h0081, 16'h0000, 1'b0);
    send_beat(16'h0000, 16'h0003, 1'b0);
    send_beat(16'hff00, 16'h0100, 1'b0);
    set_regs(16'h0080, MODE_NONE);
    send_beat(16'h0050, 16'h0000, 1'b0);
    set_regs(16'h0080, MODE_SUM);
    send_beat(16'h0007, 16'h0000, 1'b1);
    set_regs(16'h0080, MODE_MEAN);
    send_beat(16'h0001, 16'h0000, 1'b0);
    send_beat(16'h0002, 16'h0000, 1'b0);
    send_beat(16'h0005, 16'h0000, 1'b1);

    // long sets of the largest element loss
    set_regs(16'hffff, MODE_MEAN);
    for (int i = 0; i < SAT_RUN; i++) send_beat(16'h7fff, 16'h8000, i == SAT_RUN - 1);
    set_regs(16'hffff, MODE_SUM);
    for (int i = 0; i < SAT_RUN; i++) send_beat(16'h8000, 16'h7fff, i == SAT_RUN - 1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_of[ph];
      recv_stall_pct = stall_of[ph];
      for (int seg = 0; seg < SEGMENTS; seg++) random_segment(ph == 3 && seg == 5);
    end

    settle();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("tb: %0d input beats, %0d output beats checked, %0d register writes",
             sb.beats, sb.checked, sb.writes);
    $display("tb: modes none/mean/sum/unused, delta extremes, large sums, four stall mixes");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
